### hdl/min_max_normalizer_core_macros.svh
// Assertion macros for the block that checks itself.
`ifndef MIN_MAX_NORMALIZER_CORE_MACROS_SVH
`define MIN_MAX_NORMALIZER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMN_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MMN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/mmn_pkg.sv
package mmn_pkg;

   // Fixed field widths.
   localparam int VALUE_W = 32;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 7;

   // Controller states.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SETUP,
      ST_READ,
      ST_PREP,
      ST_DIVIDE,
      ST_EMIT
   } mmn_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic store;
      logic setup;
      logic read;
      logic start_div;
      logic advance;
      logic clear;
   } mmn_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_item;
      logic div_done;
   } mmn_status_type;

endpackage

### hdl/mmn_req_if.sv
interface mmn_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [mmn_pkg::VALUE_W-1:0] sample_value;
   logic                               end_of_set;

   modport source (output valid, output sample_value, output end_of_set, input ready);
   modport sink (input valid, input sample_value, input end_of_set, output ready);
endinterface

### hdl/mmn_rsp_if.sv
interface mmn_rsp_if #(
   parameter int FRAC_BITS = 16
);
   logic                        valid;
   logic                        ready;
   logic [FRAC_BITS:0]          norm_score;
   logic [mmn_pkg::INDEX_W-1:0] item_index;
   logic                        final_score;

   modport source (output valid, output norm_score, output item_index, output final_score,
                   input ready);
   modport sink (input valid, input norm_score, input item_index, input final_score,
                 output ready);
endinterface

### hdl/mmn_csr_if.sv
interface mmn_csr_if;
   logic valid;
   logic ready;
   logic invert_score;

   modport source (output valid, output invert_score, input ready);
   modport sink (input valid, input invert_score, output ready);
endinterface

### hdl/min_max_normalizer_core.sv
// Channel | Direction | Word carried
// req_ch  | in        | sample_value, end_of_set
// rsp_ch  | out       | norm_score, item_index, final_score
// csr_ch  | in        | invert_score (always ready)
//
// Words are taken while a set loads; the word that ends a set then starts the emission.
// Each score passes through a store read, a divider start, FRAC_BITS + 1 steps of the
// shared restoring divider, and the output state, which holds the score until it is taken.
// The range of a set is captured once, before its first score is read.
// No word is taken during the emission; rsp_ch stalls simply hold the current score.
// Reset is synchronous and empties the set; the value store needs no clearing pass.
`include "min_max_normalizer_core_macros.svh"

module min_max_normalizer_core #(
   parameter int MAX_ITEMS = 64,
   parameter int FRAC_BITS = 16
) (
   input logic                clock,
   input logic                reset,
   mmn_req_if.sink            req_ch,
   mmn_rsp_if.source          rsp_ch,
   mmn_csr_if.sink            csr_ch
);
   import mmn_pkg::*;

   localparam logic [FRAC_BITS:0] SCORE_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   mmn_cmd_type    cmd;
   mmn_status_type status;

   logic           score_ok;
   logic           set_end_taken;
   logic           run_end_taken;
   logic           loading;

   // Configuration writes are taken at any time.
   assign csr_ch.ready = 1'b1;

   mmn_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_end_of_set (req_ch.end_of_set),
      .rsp_ready      (rsp_ch.ready),
      .status         (status),
      .req_ready      (req_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .cmd            (cmd)
   );

   mmn_datapath #(
      .MAX_ITEMS (MAX_ITEMS),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .cfg_write    (csr_ch.valid),
      .cfg_invert   (csr_ch.invert_score),
      .sample_value (req_ch.sample_value),
      .norm_score   (rsp_ch.norm_score),
      .item_index   (rsp_ch.item_index),
      .final_score  (rsp_ch.final_score)
   );

   // Conditions watched by the checks below.
   assign score_ok      = (rsp_ch.norm_score <= SCORE_ONE);
   assign set_end_taken = req_ch.valid && req_ch.ready && req_ch.end_of_set;
   assign run_end_taken = rsp_ch.valid && rsp_ch.ready && rsp_ch.final_score;
   assign loading       = req_ch.ready && !rsp_ch.valid;

   // Loading and emission never overlap.
   `MMN_ASSERT_SAME(a_no_overlap, clock, reset, rsp_ch.valid, !req_ch.ready, "load and emit overlap")
   // A score never exceeds one.
   `MMN_ASSERT_SAME(a_score_range, clock, reset, rsp_ch.valid, score_ok, "score above one")
   // The word that ends a set stops loading at once.
   `MMN_ASSERT_NEXT(a_set_end, clock, reset, set_end_taken, !req_ch.ready, "loading after set end")
   // Once the final score is taken, loading resumes.
   `MMN_ASSERT_NEXT(a_run_end, clock, reset, run_end_taken, loading, "no return to loading")

endmodule

### hdl/mmn_ram.sv
module mmn_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/mmn_divider.sv
module mmn_divider #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mmn_pkg::VALUE_W-1:0] numerator,
   input  logic [mmn_pkg::VALUE_W-1:0] divisor,
   output logic [FRAC_BITS:0]          quotient,
   output logic                        done
);
   import mmn_pkg::*;

   // One quotient bit per cycle, FRAC_BITS + 1 bits in all.
   localparam int STEPS = FRAC_BITS + 1;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [VALUE_W:0]   rem_ff, rem_in;
   logic [FRAC_BITS:0] quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               first_ff, first_in;

   logic [VALUE_W:0]   shifted;
   logic [VALUE_W+1:0] diff;
   logic               fits;

   // Restoring step. The numerator never exceeds the divisor, so the first step compares
   // the numerator itself and every later one the doubled remainder.
   always_comb begin
      shifted = first_ff ? rem_ff : {rem_ff[VALUE_W-1:0], 1'b0};
      diff    = {1'b0, shifted} - {2'b00, divisor};
      fits    = ~diff[VALUE_W+1];
   end

   // Next values of the iteration registers.
   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      first_in = first_ff;
      if (start) begin
         rem_in   = {1'b0, numerator};
         quo_in   = '0;
         cnt_in   = CNT_W'(STEPS);
         busy_in  = 1'b1;
         first_in = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[VALUE_W:0] : shifted;
         quo_in   = {quo_ff[FRAC_BITS-1:0], fits};
         cnt_in   = cnt_ff - 1'b1;
         busy_in  = (cnt_ff != CNT_W'(1));
         first_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      first_ff <= first_in;
   end

   assign quotient = quo_ff;
   assign done     = busy_ff && (cnt_ff == CNT_W'(1));

endmodule

### hdl/mmn_datapath.sv
module mmn_datapath #(
   parameter int MAX_ITEMS = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mmn_pkg::mmn_cmd_type               cmd,
   output mmn_pkg::mmn_status_type            status,
   input  logic                               cfg_write,
   input  logic                               cfg_invert,
   input  logic signed [mmn_pkg::VALUE_W-1:0] sample_value,
   output logic [FRAC_BITS:0]                 norm_score,
   output logic [mmn_pkg::INDEX_W-1:0]        item_index,
   output logic                               final_score
);
   import mmn_pkg::*;

   localparam int ADDR_W = $clog2(MAX_ITEMS);
   localparam logic [FRAC_BITS:0] SCORE_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic                      invert_ff;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [INDEX_W-1:0]        index_ff, index_in;
   logic signed [VALUE_W-1:0] min_ff, min_in;
   logic signed [VALUE_W-1:0] max_ff, max_in;
   logic [VALUE_W-1:0]        range_ff;
   logic                      flat_ff;

   logic                      room;
   logic                      write_en;
   logic [VALUE_W-1:0]        rd_data;
   logic signed [VALUE_W:0]   above_min;
   logic signed [VALUE_W:0]   below_max;
   logic signed [VALUE_W:0]   span;
   logic [VALUE_W-1:0]        numerator;
   logic [FRAC_BITS:0]        quotient;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff <= 1'b0;
      end else if (cfg_write) begin
         invert_ff <= cfg_invert;
      end
   end

   // A word is stored only while there is room; the flag still ends the set.
   assign room     = (count_ff < COUNT_W'(MAX_ITEMS));
   assign write_en = cmd.store && room;

   // Running extremes, seeded by the first word of a set.
   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (write_en) begin
         if (count_ff == '0) begin
            min_in = sample_value;
            max_in = sample_value;
         end else begin
            if (sample_value < min_ff) begin
               min_in = sample_value;
            end
            if (sample_value > max_ff) begin
               max_in = sample_value;
            end
         end
      end
   end

   // Fill count and emission index.
   always_comb begin
      count_in = count_ff;
      index_in = index_ff;
      if (write_en) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.clear) begin
         count_in = '0;
      end
      if (cmd.setup) begin
         index_in = '0;
      end else if (cmd.advance) begin
         index_in = index_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
      end else begin
         count_ff <= count_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
      end
      index_ff <= index_in;
   end

   // Range of the set, taken once before the emission starts.
   assign span = {max_ff[VALUE_W-1], max_ff} - {min_ff[VALUE_W-1], min_ff};

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         range_ff <= span[VALUE_W-1:0];
         flat_ff  <= (max_ff == min_ff);
      end
   end

   mmn_ram #(
      .DATA_W (VALUE_W),
      .DEPTH  (MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (write_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (sample_value),
      .rd_en   (cmd.read),
      .rd_addr (index_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Distance from the minimum, or from the maximum when the score is inverted.
   always_comb begin
      above_min = {rd_data[VALUE_W-1], rd_data} - {min_ff[VALUE_W-1], min_ff};
      below_max = {max_ff[VALUE_W-1], max_ff} - {rd_data[VALUE_W-1], rd_data};
      numerator = invert_ff ? below_max[VALUE_W-1:0] : above_min[VALUE_W-1:0];
   end

   mmn_divider #(
      .FRAC_BITS (FRAC_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start_div),
      .numerator (numerator),
      .divisor   (range_ff),
      .quotient  (quotient),
      .done      (status.div_done)
   );

   assign status.last_item = ((COUNT_W'(index_ff) + 1'b1) == count_ff);

   // Result word, held in registers while it waits to be taken.
   assign norm_score  = flat_ff ? SCORE_ONE : quotient;
   assign item_index  = index_ff;
   assign final_score = status.last_item;

endmodule

### hdl/mmn_ctrl.sv
module mmn_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_end_of_set,
   input  logic                    rsp_ready,
   input  mmn_pkg::mmn_status_type status,
   output logic                    req_ready,
   output logic                    rsp_valid,
   output mmn_pkg::mmn_cmd_type    cmd
);
   import mmn_pkg::*;

   mmn_state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_end_of_set) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               state_in = status.last_item ? ST_LOAD : ST_READ;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Handshake outputs and datapath commands.
   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cmd           = '0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            cmd.store = req_valid;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         ST_READ: begin
            cmd.read = 1'b1;
         end
         ST_PREP: begin
            cmd.start_div = 1'b1;
         end
         ST_DIVIDE: begin
            cmd = '0;
         end
         ST_EMIT: begin
            rsp_valid   = 1'b1;
            cmd.advance = rsp_ready && !status.last_item;
            cmd.clear   = rsp_ready && status.last_item;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
